### sv/fcsd_pkg.sv
package fcsd_pkg;

	// moving-average window length
	localparam int WINDOW_LEN = 10;
	localparam int WIN_IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	// running sum of WINDOW_LEN signed Q8.8 samples, with headroom for the update
	localparam int SUM_W = 17 + $clog2(WINDOW_LEN);

	// floor = trunc((10*sum + 768*N) / (2560*N))
	localparam int     NUM_W       = SUM_W + 5;
	localparam longint NUM_OFFSET  = 768 * WINDOW_LEN;
	localparam longint DIVISOR     = 2560 * WINDOW_LEN;
	localparam int     DIV_W       = $clog2(DIVISOR + 1);

	// reciprocal for the constant divide: quotient estimate is low by at most one
	localparam int     RECIP_SHIFT = NUM_W - 1;
	localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / DIVISOR;
	localparam int     RECIP_W     = $clog2(RECIP + 1);
	localparam int     PROD_W      = NUM_W + RECIP_W;
	localparam int     Q_W         = 9;

	// result queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// configuration port
	localparam int              CFG_IDX_W    = 2;
	localparam int              CFG_DATA_W   = 32;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd2;
	localparam logic [31:0]     PERIOD_RESET = 32'd60000;
	localparam int              MS_PER_S     = 1000;
	localparam int              STALL_MS_W   = 26;

	// stream widths
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;

	// one classified item handed from front to back
	typedef struct packed {
		logic              rebaseline;
		logic [31:0]       now_ms;
		logic signed [7:0] floor_num;
	} item_t;

	// live configuration seen by the back end
	typedef struct packed {
		logic signed [7:0]      rebase_floor;
		logic [STALL_MS_W-1:0]  stall_ms;
		logic [31:0]            report_period_ms;
	} cfg_t;

endpackage

### sv/fcsd_front.sv
module fcsd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [15:0]   floor_sample,
	input  logic [31:0]          now_ms,
	input  logic                 rebaseline,
	input  logic signed [7:0]    rebase_floor,
	output logic                 out_valid,
	output fcsd_pkg::item_t      out_item,
	output logic [1:0]           inflight
);

	logic signed [15:0]                  win_q [fcsd_pkg::WINDOW_LEN];
	logic [fcsd_pkg::WINDOW_LEN-1:0]     win_vld_q;
	logic signed [15:0]                  rb_val_q;
	logic [fcsd_pkg::WIN_IDX_W-1:0]      pos_q;
	logic [fcsd_pkg::WIN_IDX_W-1:0]      pos_next;
	logic signed [fcsd_pkg::SUM_W-1:0]   sum_q;

	logic signed [15:0]                  base_val;
	logic signed [15:0]                  old_val;
	logic signed [fcsd_pkg::SUM_W-1:0]   base_sum;
	logic signed [fcsd_pkg::SUM_W-1:0]   sum_cur;
	logic signed [fcsd_pkg::SUM_W-1:0]   sum_next;

	logic                                v_s1;
	logic signed [fcsd_pkg::SUM_W-1:0]   sum_s1;
	logic [31:0]                         now_s1;
	logic                                rb_s1;

	logic signed [fcsd_pkg::NUM_W-1:0]   num;
	logic [fcsd_pkg::NUM_W-1:0]          mag;
	logic [fcsd_pkg::PROD_W-1:0]         prod;

	logic                                v_s2;
	logic [fcsd_pkg::Q_W-1:0]            q0_s2;
	logic [fcsd_pkg::NUM_W-1:0]          mag_s2;
	logic                                neg_s2;
	logic [31:0]                         now_s2;
	logic                                rb_s2;

	logic [fcsd_pkg::NUM_W-1:0]          rem;
	logic [fcsd_pkg::Q_W-1:0]            q;
	logic signed [fcsd_pkg::Q_W:0]       q_signed;
	logic signed [7:0]                   cur;

	// window read: entries not written since rebaseline read as the baseline
	always_comb begin
		base_val = {rebase_floor, 8'h00};
		base_sum = $signed(base_val) * $signed(fcsd_pkg::SUM_W'(fcsd_pkg::WINDOW_LEN));
		if (rebaseline) begin
			old_val = base_val;
			sum_cur = base_sum;
		end else begin
			old_val = win_vld_q[pos_q] ? win_q[pos_q] : rb_val_q;
			sum_cur = sum_q;
		end
		sum_next = sum_cur - fcsd_pkg::SUM_W'(old_val) + fcsd_pkg::SUM_W'(floor_sample);
		pos_next = (pos_q == fcsd_pkg::WIN_IDX_W'(fcsd_pkg::WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
	end

	// window storage
	always_ff @(posedge clk) begin
		if (in_valid) begin
			win_q[pos_q] <= floor_sample;
		end
	end

	// window control and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= '0;
			rb_val_q  <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
		end else if (in_valid) begin
			if (rebaseline) begin
				// only the entry written now holds a sample, the rest read the baseline
				win_vld_q <= fcsd_pkg::WINDOW_LEN'(1) << pos_q;
				rb_val_q  <= base_val;
			end else begin
				win_vld_q[pos_q] <= 1'b1;
			end
			pos_q <= pos_next;
			sum_q <= sum_next;
		end
	end

	// stage 1: summed window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			sum_s1 <= sum_next;
			now_s1 <= now_ms;
			rb_s1  <= rebaseline;
		end
	end

	// scale, offset, take magnitude and multiply by the reciprocal
	always_comb begin
		num  = (fcsd_pkg::NUM_W'(sum_s1) <<< 3) + (fcsd_pkg::NUM_W'(sum_s1) <<< 1)
			+ fcsd_pkg::NUM_W'(fcsd_pkg::NUM_OFFSET);
		mag  = num[fcsd_pkg::NUM_W-1] ? fcsd_pkg::NUM_W'(-num) : fcsd_pkg::NUM_W'(num);
		prod = fcsd_pkg::PROD_W'(mag) * fcsd_pkg::PROD_W'(fcsd_pkg::RECIP);
	end

	// stage 2: quotient estimate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			q0_s2  <= prod[fcsd_pkg::RECIP_SHIFT +: fcsd_pkg::Q_W];
			mag_s2 <= mag;
			neg_s2 <= num[fcsd_pkg::NUM_W-1];
			now_s2 <= now_s1;
			rb_s2  <= rb_s1;
		end
	end

	// correct by one, restore sign, saturate
	always_comb begin
		rem = mag_s2 - fcsd_pkg::NUM_W'(q0_s2) * fcsd_pkg::NUM_W'(fcsd_pkg::DIVISOR);
		q   = q0_s2 + fcsd_pkg::Q_W'(rem >= fcsd_pkg::NUM_W'(fcsd_pkg::DIVISOR));
		q_signed = neg_s2 ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (q_signed > 127) begin
			cur = 8'sd127;
		end else if (q_signed < -128) begin
			cur = -8'sd128;
		end else begin
			cur = q_signed[7:0];
		end
	end

	assign out_valid          = v_s2;
	assign out_item.rebaseline = rb_s2;
	assign out_item.now_ms     = now_s2;
	assign out_item.floor_num  = cur;
	assign inflight            = {1'b0, v_s1} + {1'b0, v_s2};

endmodule

### sv/fcsd_queue.sv
module fcsd_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  fcsd_pkg::item_t                push_item,
	input  logic                           pop,
	output logic                           not_empty,
	output fcsd_pkg::item_t                head_item,
	output logic [fcsd_pkg::FIFO_CNT_W-1:0] count
);

	fcsd_pkg::item_t                    mem_q [fcsd_pkg::FIFO_DEPTH];
	logic [fcsd_pkg::FIFO_IDX_W-1:0]    wr_ptr_q;
	logic [fcsd_pkg::FIFO_IDX_W-1:0]    rd_ptr_q;
	logic [fcsd_pkg::FIFO_CNT_W-1:0]    count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign not_empty = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];
	assign count     = count_q;

endmodule

### sv/fcsd_back.sv
module fcsd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  fcsd_pkg::item_t                   in_item,
	output logic                              pop,
	input  fcsd_pkg::cfg_t                    cfg,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fcsd_pkg::M_TDATA_W-1:0]    m_tdata
);

	logic signed [7:0] last_floor_q;
	logic [31:0]       last_change_q;
	logic [31:0]       last_report_q;
	logic              alarm_sent_q;
	logic              m_tvalid_q;
	logic [fcsd_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic signed [7:0] prev;
	logic [31:0]       change_ms;
	logic              sent;
	logic              change;
	logic              stall_hit;
	logic              period_hit;
	logic              send;
	logic signed [8:0] dir;

	assign pop = in_valid && (!m_tvalid_q || m_tready);

	// report decision: rebaseline, floor change, stall alarm, period
	always_comb begin
		prev      = in_item.rebaseline ? cfg.rebase_floor : last_floor_q;
		change_ms = in_item.rebaseline ? in_item.now_ms : last_change_q;
		sent      = in_item.rebaseline ? 1'b0 : alarm_sent_q;
		change    = in_item.rebaseline || (in_item.floor_num != last_floor_q);
		stall_hit = !change && !sent && (change_ms != '0) && (change_ms < in_item.now_ms)
			&& (cfg.stall_ms != '0)
			&& ((in_item.now_ms - change_ms) > 32'(cfg.stall_ms));
		period_hit = (in_item.now_ms - last_report_q) >= cfg.report_period_ms;
		send       = change || stall_hit || period_hit;
		dir        = {in_item.floor_num[7], in_item.floor_num} - {prev[7], prev};
	end

	// history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_floor_q  <= '0;
			last_change_q <= '0;
			last_report_q <= '0;
			alarm_sent_q  <= 1'b0;
		end else if (pop) begin
			if (send) begin
				last_report_q <= in_item.now_ms;
			end
			if (change) begin
				last_floor_q  <= in_item.floor_num;
				last_change_q <= in_item.now_ms;
				alarm_sent_q  <= 1'b0;
			end else if (stall_hit) begin
				alarm_sent_q  <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata_q <= {5'b0, dir, prev, in_item.floor_num, stall_hit, send};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### sv/floor_change_stall_detector.sv
// Floor change and stall detector. Takes one floor estimate per cycle while s_tready is
// high (Q8.8 sample, millisecond timestamp, rebaseline flag) and returns one report item
// per input item, in order. Sustained rate is one item per clock while m_tready stays
// high. The window sum registers at the input accept edge, the reciprocal multiply result
// is registered after it, the quotient correction is pushed into a four-entry queue, and
// the report decision on the queue head loads the output register. s_tready follows
// a credit count over the queue and the two front stages, so backpressure on the
// result side stops intake once four items wait there, with one more item held in
// the output register. Configuration writes take effect on the next cycle.
module floor_change_stall_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	// input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fcsd_pkg::S_TDATA_W-1:0]      s_tdata,   // floor_sample[15:0],
	                                                       // now_ms[47:16], rebaseline[48]
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fcsd_pkg::M_TDATA_W-1:0]      m_tdata,   // send_report[0], alarm[1],
	                                                       // current_floor[9:2],
	                                                       // previous_floor[17:10],
	                                                       // direction[26:18]
	// configuration writes
	input  logic                                cfg_wr_en,
	input  logic [fcsd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [fcsd_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

	fcsd_pkg::cfg_t                        cfg_q;
	logic                                  in_accept;
	logic                                  front_valid;
	fcsd_pkg::item_t                       front_item;
	logic [1:0]                            inflight;
	logic                                  q_not_empty;
	fcsd_pkg::item_t                       q_head;
	logic [fcsd_pkg::FIFO_CNT_W-1:0]       q_count;
	logic                                  q_pop;
	logic [fcsd_pkg::FIFO_CNT_W:0]         occupancy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rebase_floor     <= '0;
			cfg_q.stall_ms         <= '0;
			cfg_q.report_period_ms <= fcsd_pkg::PERIOD_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				fcsd_pkg::REG_BASELINE: begin
					cfg_q.rebase_floor <= cfg_wr_data[7:0];
				end
				fcsd_pkg::REG_STALL: begin
					cfg_q.stall_ms <= fcsd_pkg::STALL_MS_W'(cfg_wr_data[15:0])
						* fcsd_pkg::STALL_MS_W'(fcsd_pkg::MS_PER_S);
				end
				fcsd_pkg::REG_PERIOD: begin
					cfg_q.report_period_ms <= cfg_wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// credit: items in the front stages plus queued items stay within queue depth
	assign occupancy = (fcsd_pkg::FIFO_CNT_W + 1)'(q_count)
		+ (fcsd_pkg::FIFO_CNT_W + 1)'(inflight);
	assign s_tready  = occupancy < (fcsd_pkg::FIFO_CNT_W + 1)'(fcsd_pkg::FIFO_DEPTH);
	assign in_accept = s_tvalid && s_tready;

	fcsd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_accept),
		.floor_sample   (s_tdata[15:0]),
		.now_ms         (s_tdata[47:16]),
		.rebaseline     (s_tdata[48]),
		.rebase_floor   (cfg_q.rebase_floor),
		.out_valid      (front_valid),
		.out_item       (front_item),
		.inflight       (inflight)
	);

	fcsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_item (front_item),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (q_head),
		.count     (q_count)
	);

	fcsd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_not_empty),
		.in_item  (q_head),
		.pop      (q_pop),
		.cfg      (cfg_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### tb/sv/tb_floor_change_stall_detector.sv
module tb_floor_change_stall_detector;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [fcsd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int                   CYCLE_LIMIT = 600000;
	localparam int                   SAMPLE_MAX  = 32767;
	localparam int                   SAMPLE_MIN  = -32768;

	// one input item: raw Q8.8 estimate, timestamp, rebaseline flag
	typedef struct {
		logic signed [15:0] sample;
		logic [31:0]        now;
		logic               rebase;
	} sample_t;

	// one report item
	typedef struct {
		logic               send;
		logic               alarm;
		logic signed [7:0]  cur;
		logic signed [7:0]  prev;
		logic signed [8:0]  dir;
	} report_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [fcsd_pkg::S_TDATA_W-1:0]      s_tdata = '0;   // floor_sample[15:0],
	                                                     // now_ms[47:16], rebaseline[48]
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [fcsd_pkg::M_TDATA_W-1:0]      m_tdata;        // send_report[0], alarm[1],
	                                                     // current_floor[9:2],
	                                                     // previous_floor[17:10],
	                                                     // direction[26:18]
	logic                                cfg_wr_en = 1'b0;
	logic [fcsd_pkg::CFG_IDX_W-1:0]      cfg_idx = '0;
	logic [fcsd_pkg::CFG_DATA_W-1:0]     cfg_wr_data = '0;

	floor_change_stall_detector uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_idx     (cfg_idx),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor configuration copy
	int          base_floor = 0;
	logic [15:0] stall_s = '0;
	logic [31:0] period_ms = fcsd_pkg::PERIOD_RESET;

	// predictor state copy
	int          win [fcsd_pkg::WINDOW_LEN];
	int          win_pos = 0;
	int          win_sum = 0;
	int          last_floor = 0;
	logic [31:0] last_change = '0;
	logic [31:0] last_report = '0;
	logic        alarm_sent = 1'b0;

	sample_t sample_q[$];
	report_t report_q[$];
	int      errors = 0;
	int      cycles = 0;

	// stimulus walk state
	logic [31:0] walk_ms = '0;
	int          walk_level = 0;

	initial begin
		foreach (win[i])
			win[i] = 0;
	end

	// moving average, floor decision and report cause for one item
	function automatic report_t track_floor(input sample_t it);
		report_t     r;
		int          b;
		longint      num;
		longint      q;
		logic        change;
		logic [31:0] since_change;
		logic [31:0] since_report;
		logic [31:0] stall_ms;
		r.send = 1'b0;
		r.alarm = 1'b0;
		change = 1'b0;
		if (it.rebase) begin
			b = base_floor * 256;
			for (int i = 0; i < fcsd_pkg::WINDOW_LEN; i++)
				win[i] = b;
			win_sum = b * fcsd_pkg::WINDOW_LEN;
			last_floor = base_floor;
			last_change = it.now;
			alarm_sent = 1'b0;
		end
		win_sum = win_sum - win[win_pos] + int'(it.sample);
		win[win_pos] = int'(it.sample);
		win_pos = (win_pos + 1 >= fcsd_pkg::WINDOW_LEN) ? 0 : win_pos + 1;

		// trunc(avg + 0.3), integer form, division truncates toward zero
		num = longint'(win_sum) * 10 + longint'(768 * fcsd_pkg::WINDOW_LEN);
		q = num / longint'(2560 * fcsd_pkg::WINDOW_LEN);
		if (q > 127)
			q = 127;
		if (q < -128)
			q = -128;
		r.cur = q[7:0];
		r.prev = last_floor[7:0];
		r.dir = 9'(int'(q) - last_floor);

		since_change = it.now - last_change;
		since_report = it.now - last_report;
		stall_ms = stall_s * 32'd1000;
		if (it.rebase) begin
			r.send = 1'b1;
			change = 1'b1;
			alarm_sent = 1'b0;
		end else if (int'(q) != last_floor) begin
			r.send = 1'b1;
			change = 1'b1;
			alarm_sent = 1'b0;
		end else if (!alarm_sent && last_change != 0 && last_change < it.now &&
				stall_s != 0 && since_change > stall_ms) begin
			r.send = 1'b1;
			r.alarm = 1'b1;
			alarm_sent = 1'b1;
		end else if (since_report >= period_ms) begin
			r.send = 1'b1;
		end

		if (r.send)
			last_report = it.now;
		if (change) begin
			last_floor = int'(q);
			last_change = it.now;
		end
		return r;
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// input side
	sample_t tx_item;
	int      tx_gap = 0;
	bit      tx_quiet = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				report_q.push_back(track_floor(tx_item));
			if (!(s_tvalid && !s_tready)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					tx_item = sample_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'b0, tx_item.rebase, tx_item.now, tx_item.sample};
					if ($urandom_range(0, 49) == 0)
						tx_quiet = !tx_quiet;
					tx_gap = pick_gap(tx_quiet);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: random backpressure, in-order compare
	int rx_stall = 0;
	bit rx_quiet = 1'b0;

	always @(posedge clk) begin
		report_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (report_q.size() == 0) begin
					$display("%0t ns: result item with none expected, got %h", $time, m_tdata);
					errors++;
				end else begin
					want = report_q.pop_front();
					check_field("send_report", want.send, m_tdata[0]);
					check_field("alarm", want.alarm, m_tdata[1]);
					check_field("current_floor", want.cur, $signed(m_tdata[9:2]));
					check_field("previous_floor", want.prev, $signed(m_tdata[17:10]));
					check_field("direction", want.dir, $signed(m_tdata[26:18]));
				end
			end
			if ($urandom_range(0, 99) == 0)
				rx_quiet = !rx_quiet;
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					rx_stall = pick_gap(rx_quiet);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic add_item(input int sample, input logic [31:0] now, input logic rebase);
		sample_t it;
		it.sample = sample[15:0];
		it.now = now;
		it.rebase = rebase;
		sample_q.push_back(it);
	endtask

	task automatic write_reg(input logic [fcsd_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			fcsd_pkg::REG_BASELINE: base_floor = int'($signed(data[7:0]));
			fcsd_pkg::REG_STALL:    stall_s = data[15:0];
			fcsd_pkg::REG_PERIOD:   period_ms = data;
			default: begin
			end
		endcase
	endtask

	// all items taken and all results back
	task automatic drain();
		while (sample_q.size() > 0 || s_tvalid || report_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// floor walk: noisy samples around a level that moves now and then
	task automatic gen_walk(input int n);
		int r;
		int s;
		logic rb;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			rb = (r < 4);
			if (rb)
				walk_level = base_floor;
			else if (r < 12)
				walk_level += ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 3);
			if (walk_level > 125)
				walk_level = 125;
			if (walk_level < -128)
				walk_level = -128;

			r = $urandom_range(0, 99);
			if (r < 85)
				s = walk_level * 256 + $urandom_range(0, 300) - 150;
			else if (r < 95)
				s = int'($signed(16'($urandom)));
			else
				s = $urandom_range(0, 1) ? SAMPLE_MAX - $urandom_range(0, 3)
				                         : SAMPLE_MIN + $urandom_range(0, 3);
			if (s > SAMPLE_MAX)
				s = SAMPLE_MAX;
			if (s < SAMPLE_MIN)
				s = SAMPLE_MIN;

			r = $urandom_range(0, 99);
			if (r < 3)
				walk_ms = walk_ms;
			else if (r < 80)
				walk_ms += $urandom_range(1, 2000);
			else if (r < 93)
				walk_ms += $urandom_range(2000, 80000);
			else
				walk_ms = $urandom;
			add_item(s, walk_ms, rb);
		end
	endtask

	task automatic run_phase(input int base, input int stall, input logic [31:0] period,
			input int n);
		drain();
		write_reg(fcsd_pkg::REG_BASELINE, {24'($urandom), 8'(base)});
		write_reg(fcsd_pkg::REG_STALL, {16'($urandom), 16'(stall)});
		write_reg(fcsd_pkg::REG_PERIOD, period);
		write_reg(REG_UNUSED, $urandom);
		@(posedge clk);
		gen_walk(n);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset configuration
		add_item(0, 32'd0, 1'b0);
		for (int i = 1; i <= 10; i++)
			add_item(SAMPLE_MAX, 32'(i * 100), 1'b0);
		add_item(SAMPLE_MIN, 32'hFFFF_FFFF, 1'b1);
		for (int i = 0; i < 8; i++)
			add_item(SAMPLE_MIN, 32'h10 + 32'(i * 70000), 1'b0);
		add_item(16'sh5555, 32'hAAAA_AAAA, 1'b1);
		add_item(-16'sh5556, 32'h5555_5555, 1'b0);
		add_item(-128, 32'hAAAA_AAAB, 1'b0);
		add_item(0, 32'h0, 1'b1);

		run_phase(3, 5, 32'd10000, 185);
		run_phase(-128, 0, 32'd0, 185);
		run_phase(127, 65535, 32'hFFFF_FFFF, 185);
		run_phase(-5, 2, 32'd2500, 185);
		run_phase(0, 1, 32'd60000, 185);
		run_phase(int'($signed(8'($urandom))), $urandom_range(0, 30),
			$urandom_range(0, 200000), 185);
		run_phase(1, 3, 32'd5000, 150);
		drain();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
